// ===== src/bfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfq_pkg: shared types and constants
// Command and status bundles between the controller and the datapath,
// plus the IEEE single-precision field constants.
// ----------------------------------------------------------------------------
package bfq_pkg;

   localparam logic [31:0] SIGN_FIELD = 32'h8000_0000;
   localparam logic [31:0] EXP_FIELD  = 32'h7f80_0000;
   localparam logic [22:0] FRAC_FIELD = 23'h7f_ffff;
   localparam logic [23:0] HALF_ROUND = 24'h40_0000;
   localparam logic [23:0] HIDDEN_ONE = 24'h80_0000;

   localparam logic [4:0] MB_RESET = 5'd8;
   localparam logic [4:0] MB_MIN   = 5'd1;
   localparam logic [4:0] MB_MAX   = 5'd23;
   localparam logic [4:0] FRAC_W   = 5'd23;
   localparam logic [4:0] MASK_TOP = 5'd24;

   localparam logic [7:0] EXP_INF = 8'hff;

   // result class decided in the align stage
   localparam logic [1:0] KIND_PACKED  = 2'd0;
   localparam logic [1:0] KIND_SPECIAL = 2'd1;
   localparam logic [1:0] KIND_ZERO    = 2'd2;
   localparam logic [1:0] KIND_NORM    = 2'd3;

   typedef struct packed {
      logic load;
      logic flush_start;
      logic rd_en;
      logic rd_last;
   } bfq_cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } bfq_status_type;

endpackage

// ===== src/bfq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfq_ctrl: block sequencer
// Takes words while idle, decides when a block closes and then walks the
// store in arrival order, one read per cycle, until the pipeline drains.
// ----------------------------------------------------------------------------
module bfq_ctrl #(
   parameter int MAX_BLOCK = 64,
   parameter int COUNT_W   = 7,
   parameter int ADDR_W    = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_block_end,
   input  logic [COUNT_W-1:0]      fill_count,
   input  bfq_pkg::bfq_status_type status,
   output bfq_pkg::bfq_cmd_type    cmd,
   output logic [ADDR_W-1:0]       rd_addr,
   output logic                    busy
);
   import bfq_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FLUSH = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [COUNT_W-1:0] last_idx_ff, last_idx_in;
   logic               closes;

   assign closes = req_block_end || (fill_count == COUNT_W'(MAX_BLOCK - 1));

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (closes) begin
                  cmd.flush_start = 1'b1;
                  last_idx_in     = fill_count;
                  idx_in          = '0;
                  state_in        = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_last = (idx_ff == last_idx_ff);
            idx_in      = idx_ff + COUNT_W'(1);
            if (cmd.rd_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr = idx_ff[ADDR_W-1:0];
   assign busy    = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
   end

   // the read walk never runs past the words actually stored
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (idx_ff <= last_idx_ff))
      else $error("bfq_ctrl: read index beyond block length");

   // a block close always hands over to the read walk
   assert property (@(posedge clock) disable iff (reset)
      cmd.flush_start |=> (state_ff == ST_FLUSH) && (idx_ff == '0))
      else $error("bfq_ctrl: flush did not start at entry zero");

   // after the last read the sequencer waits for the pipeline
   assert property (@(posedge clock) disable iff (reset)
      cmd.rd_last |=> (state_ff == ST_DRAIN) && status.pipe_busy)
      else $error("bfq_ctrl: drain entered without data in flight");

endmodule

// ===== src/bfq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfq_datapath: block store and requantizer pipeline
// Holds the block words and the running max exponent; a read stage, an
// align/round stage and a normalize stage produce the output beats.
// ----------------------------------------------------------------------------
module bfq_datapath #(
   parameter int MAX_BLOCK = 64,
   parameter int COUNT_W   = 7,
   parameter int ADDR_W    = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bfq_pkg::bfq_cmd_type    cmd,
   input  logic [ADDR_W-1:0]       rd_addr,
   input  logic [31:0]             req_value_bits,
   input  logic [4:0]              mantissa_bits,
   output logic [COUNT_W-1:0]      fill_count,
   output bfq_pkg::bfq_status_type status,
   output logic                    rsp_valid,
   output logic [31:0]             rsp_quantized_bits,
   output logic                    rsp_last
);
   import bfq_pkg::*;

   function automatic logic [4:0] msb_pos(input logic [22:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 23; i++) begin
         if (v[i]) begin
            p = 5'(i);
         end
      end
      return p;
   endfunction

   // ---------------- block store and bookkeeping ----------------
   logic [31:0]        store [MAX_BLOCK];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         max_exp_ff, max_exp_in;
   logic [7:0]         shared_exp_ff;
   logic [7:0]         in_exp;
   logic [7:0]         max_next;

   assign in_exp   = req_value_bits[30:23];
   assign max_next = (in_exp > max_exp_ff) ? in_exp : max_exp_ff;

   always_comb begin
      count_in   = count_ff;
      max_exp_in = max_exp_ff;
      if (cmd.load) begin
         count_in   = cmd.flush_start ? '0 : count_ff + COUNT_W'(1);
         max_exp_in = cmd.flush_start ? '0 : max_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         max_exp_ff <= '0;
      end else begin
         count_ff   <= count_in;
         max_exp_ff <= max_exp_in;
      end
      if (cmd.flush_start) begin
         shared_exp_ff <= max_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         store[count_ff[ADDR_W-1:0]] <= req_value_bits;
      end
   end

   assign fill_count = count_ff;

   // ---------------- read stage ----------------
   logic        rd_valid_ff, rd_last_ff;
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en;
      end
      rd_last_ff <= cmd.rd_last;
      if (cmd.rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   // ---------------- align / round stage ----------------
   logic [7:0]  w_exp, shift;
   logic [23:0] aligned, rnd, keep_mask;
   logic [24:0] m_sum;
   logic [23:0] m_val;
   logic [22:0] tm;
   logic [4:0]  mask_sh;
   logic [1:0]  kind;

   assign w_exp     = rd_data_ff[30:23];
   assign shift     = shared_exp_ff - w_exp;
   assign aligned   = (shift[7:5] != 3'd0) ? '0 :
                      ((HIDDEN_ONE | {1'b0, rd_data_ff[22:0]}) >> shift[4:0]);
   assign rnd       = HALF_ROUND >> (mantissa_bits - MB_MIN);
   assign mask_sh   = MASK_TOP - mantissa_bits;
   assign keep_mask = (({1'b0, FRAC_FIELD}) >> mask_sh) << mask_sh;
   assign m_sum     = {1'b0, aligned} + {1'b0, rnd};
   assign m_val     = m_sum[24] ? aligned : m_sum[23:0];
   assign tm        = m_val[22:0] & keep_mask[22:0];

   always_comb begin
      if (shift == 8'd0 || (shift == 8'd1 && m_val[23])) begin
         kind = KIND_PACKED;
      end else if (shared_exp_ff == EXP_INF) begin
         kind = KIND_SPECIAL;
      end else if (tm == '0) begin
         kind = KIND_ZERO;
      end else begin
         kind = KIND_NORM;
      end
   end

   logic        a_valid_ff, a_last_ff, a_sign_ff;
   logic [7:0]  a_exp_ff;
   logic [22:0] a_tm_ff;
   logic [1:0]  a_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= rd_valid_ff;
      end
      a_last_ff <= rd_last_ff;
      a_sign_ff <= rd_data_ff[31];
      a_exp_ff  <= shared_exp_ff;
      a_tm_ff   <= tm;
      a_kind_ff <= kind;
   end

   assign status.pipe_busy = rd_valid_ff | a_valid_ff;

   // ---------------- normalize stage ----------------
   logic [4:0]  p;
   logic [8:0]  exp_sum;
   logic [7:0]  norm_exp;
   logic [23:0] norm_frac;
   logic [30:0] sub_mag;
   logic [31:0] packed_word;
   logic [31:0] result;

   assign p           = msb_pos(a_tm_ff);
   assign exp_sum     = {1'b0, a_exp_ff} + {4'd0, p};
   assign norm_exp    = 8'(exp_sum - 9'(FRAC_W));
   assign norm_frac   = {1'b0, a_tm_ff} << (FRAC_W - p);
   assign sub_mag     = {8'd0, a_tm_ff} << (a_exp_ff - 8'd1);
   assign packed_word = {a_sign_ff, a_exp_ff, a_tm_ff};

   always_comb begin
      case (a_kind_ff)
         KIND_PACKED:  result = packed_word;
         KIND_SPECIAL: result = packed_word | ((a_tm_ff != '0) ? {8'd0, HALF_ROUND} : '0);
         KIND_ZERO:    result = '0;
         KIND_NORM: begin
            if (exp_sum > 9'(FRAC_W)) begin
               result = {a_sign_ff, norm_exp, norm_frac[22:0]};
            end else begin
               result = {a_sign_ff, sub_mag};
            end
         end
         default:      result = '0;
      endcase
   end

   logic        out_valid_ff, out_last_ff;
   logic [31:0] out_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= a_valid_ff;
      end
      out_last_ff <= a_last_ff;
      out_bits_ff <= result;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_last           = out_valid_ff & out_last_ff;
   assign rsp_quantized_bits = out_bits_ff;

   // store writes and reads never collide
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.rd_en))
      else $error("bfq_datapath: load during flush read");

   // fill count stays inside the store
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_BLOCK - 1))
      else $error("bfq_datapath: fill count out of range");

   // a closed block leaves an empty store and cleared exponent tracker
   assert property (@(posedge clock) disable iff (reset)
      cmd.flush_start |=> (count_ff == '0) && (max_exp_ff == '0))
      else $error("bfq_datapath: block state not cleared on flush");

endmodule

// ===== src/block_float_quantizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_float_quantizer_top: block floating-point requantizer
// Collects single-precision words of one channel block and replays them
// quantized against the block's largest exponent.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive req_value_bits / req_block_end and raise start; a beat is
//    taken on a clock edge with start high and busy low. A word that does
//    not close the block leaves busy low.
//  - A block closes on req_block_end or when MAX_BLOCK words are held. Busy
//    then rises and the store is read back one word per cycle.
//  - Output: each quantized word shows on rsp_quantized_bits for one cycle
//    with rsp_valid; rsp_last marks the final word. After the first result
//    the rest follow one per cycle; busy drops once the last result is out.
//    Words go in and come out through the single-port block store one at a
//    time.
//  - The receiver cannot stall; results are never held.
//  - csr_we / csr_wdata write mantissa_bits (reset 8) while the block is
//    idle (user's duty, not enforced); 0 acts as 1, values above 23 as 23.
//  - Reset (synchronous) empties the block and clears the max exponent.
// ----------------------------------------------------------------------------
module block_float_quantizer_top #(
   parameter int MAX_BLOCK = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_value_bits,
   input  logic        req_block_end,
   output logic        rsp_valid,
   output logic [31:0] rsp_quantized_bits,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);
   import bfq_pkg::*;

   // fill count must hold MAX_BLOCK - 1; address needs at least one bit
   localparam int COUNT_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int ADDR_W  = COUNT_W;

   // mantissa width register, clamped into the legal range on use
   logic [4:0] mantissa_bits_ff, mantissa_bits_in;
   logic [4:0] mb_eff;

   assign mantissa_bits_in = csr_we ? csr_wdata : mantissa_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mantissa_bits_ff <= MB_RESET;
      end else begin
         mantissa_bits_ff <= mantissa_bits_in;
      end
   end

   assign mb_eff = (mantissa_bits_ff < MB_MIN) ? MB_MIN :
                   (mantissa_bits_ff > MB_MAX) ? MB_MAX : mantissa_bits_ff;

   bfq_cmd_type        cmd;
   bfq_status_type     status;
   logic [ADDR_W-1:0]  rd_addr;
   logic [COUNT_W-1:0] fill_count;

   bfq_ctrl #(
      .MAX_BLOCK (MAX_BLOCK),
      .COUNT_W   (COUNT_W),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_block_end (req_block_end),
      .fill_count    (fill_count),
      .status        (status),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .busy          (busy)
   );

   bfq_datapath #(
      .MAX_BLOCK (MAX_BLOCK),
      .COUNT_W   (COUNT_W),
      .ADDR_W    (ADDR_W)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .rd_addr            (rd_addr),
      .req_value_bits     (req_value_bits),
      .mantissa_bits      (mb_eff),
      .fill_count         (fill_count),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_quantized_bits (rsp_quantized_bits),
      .rsp_last           (rsp_last)
   );

endmodule
